// ===== hw/rtl/gdtb_pkg.sv =====
// package for the grid distance transform block: constants, types, fsm states
package gdtb_pkg;

    localparam int DEF_MAX_COLS   = 64;
    localparam int DEF_MAX_ROWS   = 64;
    localparam int DEF_DIST_WIDTH = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int DIM_W      = 7;
    localparam int COORD_W    = 6;
    localparam int OUT_W      = 16;
    localparam int ACT_W      = 2;

    localparam int STEP_STRAIGHT = 256;
    localparam int STEP_DIAG     = 362;
    localparam int BAND_TOL      = 128;

    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND = 2'd2;

    localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_RUN   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_FWD,
        ST_BWD,
        ST_RDWAIT,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               occupied;
    } cmd_t;

    typedef struct packed {
        logic [OUT_W-1:0] distance;
        logic             in_band;
        logic             reachable;
    } rsp_t;

endpackage

// ===== hw/rtl/gdtb_if.sv =====
// valid/ready channel interface carrying one payload beat
interface gdtb_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/gdtb_ram.sv =====
// generic single-port ram with registered read
module gdtb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== hw/rtl/gdtb_cell.sv =====
// one chamfer cell: holds one row entry and relaxes it against neighbors
module gdtb_cell
    import gdtb_pkg::*;
#(
    parameter int DIST_WIDTH = DEF_DIST_WIDTH
) (
    input  logic                  clk,
    input  logic                  load,
    input  logic [DIST_WIDTH-1:0] load_val,
    input  logic                  shift,
    input  logic [DIST_WIDTH-1:0] prev_val,
    input  logic [DIST_WIDTH-1:0] side_val,
    input  logic                  side_en,
    input  logic [DIST_WIDTH-1:0] adj_row_a,
    input  logic                  adj_a_en,
    input  logic [DIST_WIDTH-1:0] adj_row_b,
    input  logic                  adj_b_en,
    input  logic [DIST_WIDTH-1:0] adj_row_c,
    input  logic                  adj_c_en,
    output logic [DIST_WIDTH-1:0] val
);
    localparam logic [DIST_WIDTH:0] DMAX = {1'b0, {DIST_WIDTH{1'b1}}};

    logic [DIST_WIDTH-1:0] val_reg;

    function automatic logic [DIST_WIDTH-1:0] sadd(input logic [DIST_WIDTH-1:0] a,
                                                   input int unsigned s);
        logic [DIST_WIDTH:0] t;
        t = {1'b0, a} + (DIST_WIDTH+1)'(s);
        return (t > DMAX) ? DMAX[DIST_WIDTH-1:0] : t[DIST_WIDTH-1:0];
    endfunction

    // relaxed value of incoming entry: side is a straight step in the row,
    // a is straight from the adjacent row, b and c are diagonals
    logic [DIST_WIDTH-1:0] m0, m1, m2, m3, ca, cb, cc, cs;
    always_comb
    begin
        cs = sadd(side_val, STEP_STRAIGHT);
        ca = sadd(adj_row_a, STEP_STRAIGHT);
        cb = sadd(adj_row_b, STEP_DIAG);
        cc = sadd(adj_row_c, STEP_DIAG);
        m0 = prev_val;
        m1 = (side_en && cs < m0) ? cs : m0;
        m2 = (adj_a_en && ca < m1) ? ca : m1;
        m3 = (adj_b_en && cb < m2) ? cb : m2;
        val = val_reg;
        if (adj_c_en && cc < m3)
        begin
            m3 = cc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            val_reg <= load_val;
        end
        else if (shift)
        begin
            val_reg <= m3;
        end
    end
endmodule

// ===== hw/rtl/gdtb_row.sv =====
// row buffer built as a chain of cells; holds the previous row of a sweep
module gdtb_row
    import gdtb_pkg::*;
#(
    parameter int MAX_COLS   = DEF_MAX_COLS,
    parameter int DIST_WIDTH = DEF_DIST_WIDTH
) (
    input  logic                  clk,
    input  logic                  shift,
    input  logic [DIST_WIDTH-1:0] new_val,
    input  logic                  side_en,
    input  logic                  adj_a_en,
    input  logic                  adj_b_en,
    input  logic                  adj_c_en,
    output logic [DIST_WIDTH-1:0] relaxed
);
    // chain: every row takes exactly MAX_COLS shifts, so with column c
    // entering now, cell 0 holds the neighbor one step back in the row,
    // cell MAX_COLS-1 the same column of the previous row, and cells
    // MAX_COLS and MAX_COLS-2 its two diagonal neighbors
    logic [DIST_WIDTH-1:0] v [MAX_COLS+1];
    logic [DIST_WIDTH-1:0] head_val;

    // head cell stores the relaxed entry, same as the value written back
    gdtb_cell #(.DIST_WIDTH(DIST_WIDTH)) u_head (
        .clk      (clk),
        .load     (1'b0),
        .load_val (new_val),
        .shift    (shift),
        .prev_val (new_val),
        .side_val (v[0]),
        .side_en  (side_en),
        .adj_row_a(v[MAX_COLS-1]),
        .adj_a_en (adj_a_en),
        .adj_row_b(v[MAX_COLS]),
        .adj_b_en (adj_b_en),
        .adj_row_c(v[MAX_COLS-2 > 0 ? MAX_COLS-2 : 0]),
        .adj_c_en (adj_c_en),
        .val      (head_val)
    );

    assign v[0] = head_val;

    genvar k;
    generate
        for (k = 1; k <= MAX_COLS; k++)
        begin : g_cell
            gdtb_cell #(.DIST_WIDTH(DIST_WIDTH)) u_cell (
                .clk      (clk),
                .load     (1'b0),
                .load_val (v[k-1]),
                .shift    (shift),
                .prev_val (v[k-1]),
                .side_val (v[k-1]),
                .side_en  (1'b0),
                .adj_row_a(v[k-1]),
                .adj_a_en (1'b0),
                .adj_row_b(v[k-1]),
                .adj_b_en (1'b0),
                .adj_row_c(v[k-1]),
                .adj_c_en (1'b0),
                .val      (v[k])
            );
        end
    endgenerate

    // combinational relaxed value of the entering entry, for write-back
    logic [DIST_WIDTH-1:0] c_side, c_up, c_d1, c_d2, r1, r2, r3, r4;
    localparam logic [DIST_WIDTH:0] DMAX = {1'b0, {DIST_WIDTH{1'b1}}};
    function automatic logic [DIST_WIDTH-1:0] sadd(input logic [DIST_WIDTH-1:0] a,
                                                   input int unsigned s);
        logic [DIST_WIDTH:0] t;
        t = {1'b0, a} + (DIST_WIDTH+1)'(s);
        return (t > DMAX) ? DMAX[DIST_WIDTH-1:0] : t[DIST_WIDTH-1:0];
    endfunction
    always_comb
    begin
        c_side = sadd(v[0], STEP_STRAIGHT);
        c_up   = sadd(v[MAX_COLS-1], STEP_STRAIGHT);
        c_d1   = sadd(v[MAX_COLS], STEP_DIAG);
        c_d2   = sadd(v[MAX_COLS-2 > 0 ? MAX_COLS-2 : 0], STEP_DIAG);
        r1 = (side_en && c_side < new_val) ? c_side : new_val;
        r2 = (adj_a_en && c_up < r1) ? c_up : r1;
        r3 = (adj_b_en && c_d1 < r2) ? c_d1 : r2;
        r4 = (adj_c_en && c_d2 < r3) ? c_d2 : r3;
        relaxed = r4;
    end
endmodule

// ===== hw/rtl/grid_distance_transform_band.sv =====
// top level of the grid distance transform with band flag
// usage:
//   cmd channel (sink) carries beats of action, col, row, occupied
//   rsp channel (source) returns one beat per command: distance,
//   in_band and reachable
//   configuration is written through cfg_we / cfg_idx / cfg_data while idle
// sequencing:
//   write occupancy: result registered in the response state after accept
//   read cell: result after a read wait and the response state (registered ram read)
//   run: an init sweep, then a forward and a backward sweep; the init
//   sweep reads occupancy then writes distance for each cell, the forward
//   and the backward sweep read, get the data back and write each cell,
//   gated by the single port of the distance ram, and each sweep spends
//   MAX_COLS-cols padding shifts between rows; the row of cells between
//   rows is a shift chain of MAX_COLS+1 cells
// throughput: one command at a time; the next command is taken the cycle
//   after the response beat has been handed over
// reset: occupancy all free (cleared by a sweep over all MAX_COLS*MAX_ROWS
//   cells after reset, no command taken meanwhile), any_source cleared,
//   registers to 64, 64, 768
// stall: the response register holds its beat while rsp.ready is low
module grid_distance_transform_band
    import gdtb_pkg::*;
#(
    parameter int MAX_COLS   = DEF_MAX_COLS,
    parameter int MAX_ROWS   = DEF_MAX_ROWS,
    parameter int DIST_WIDTH = DEF_DIST_WIDTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    gdtb_if.sink                  cmd,
    gdtb_if.source                rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data
);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int AW    = CW + RW;
    localparam int CELLS = MAX_COLS * MAX_ROWS;
    localparam logic [DIST_WIDTH-1:0] DMAX = {DIST_WIDTH{1'b1}};

    // configuration registers
    logic [DIM_W-1:0]      cols_cfg_reg, rows_cfg_reg;
    logic [CFG_DATA_W-1:0] band_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_cfg_reg <= DIM_W'(64);
            rows_cfg_reg <= DIM_W'(64);
            band_reg     <= CFG_DATA_W'(768);
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                CFG_COLS: cols_cfg_reg <= cfg_data[DIM_W-1:0];
                CFG_ROWS: rows_cfg_reg <= cfg_data[DIM_W-1:0];
                CFG_BAND: band_reg     <= cfg_data;
                default:  ;
            endcase
        end
    end

    // clamped dimensions, as counts
    logic [CW:0] cols_n;
    logic [RW:0] rows_n;
    always_comb
    begin
        if (cols_cfg_reg == '0)
            cols_n = (CW+1)'(1);
        else if (32'(cols_cfg_reg) > MAX_COLS)
            cols_n = (CW+1)'(MAX_COLS);
        else
            cols_n = (CW+1)'(cols_cfg_reg);
        if (rows_cfg_reg == '0)
            rows_n = (RW+1)'(1);
        else if (32'(rows_cfg_reg) > MAX_ROWS)
            rows_n = (RW+1)'(MAX_ROWS);
        else
            rows_n = (RW+1)'(rows_cfg_reg);
    end
    logic [CW-1:0] col_last;
    logic [RW-1:0] row_last;
    assign col_last = CW'(cols_n - 1'b1);
    assign row_last = RW'(rows_n - 1'b1);

    // state
    state_t state_reg, state_next;
    logic [CW-1:0] c_reg, c_next;
    logic [RW-1:0] r_reg, r_next;
    logic          any_reg, any_next;
    logic          any_run_reg, any_run_next;
    logic          clr_reg, clr_next;
    logic [AW:0]   clr_cnt_reg, clr_cnt_next;
    logic [1:0]    ph_reg, ph_next;
    cmd_t          cmd_reg, cmd_next;
    rsp_t          out_reg, out_next;
    logic          out_vld_reg, out_vld_next;

    // memories
    logic                  occ_we, dist_we;
    logic [AW-1:0]         occ_addr, dist_addr;
    logic                  occ_wd, occ_rd;
    logic [DIST_WIDTH-1:0] dist_wd, dist_rd;

    gdtb_ram #(.WIDTH(1), .DEPTH(CELLS)) u_occ (
        .clk(clk), .we(occ_we), .addr(occ_addr), .wdata(occ_wd), .rdata(occ_rd)
    );
    gdtb_ram #(.WIDTH(DIST_WIDTH), .DEPTH(CELLS)) u_dist (
        .clk(clk), .we(dist_we), .addr(dist_addr), .wdata(dist_wd), .rdata(dist_rd)
    );

    // chamfer row chain; pipeline: ph 0 issue read, ph 1 data back, ph 2 write
    logic                  chain_shift;
    logic [DIST_WIDTH-1:0] relaxed;
    logic                  fwd;
    logic                  e_side, e_up, e_d1, e_d2;

    gdtb_row #(.MAX_COLS(MAX_COLS), .DIST_WIDTH(DIST_WIDTH)) u_row (
        .clk(clk), .shift(chain_shift), .new_val(dist_rd),
        .side_en(e_side), .adj_a_en(e_up), .adj_b_en(e_d1), .adj_c_en(e_d2),
        .relaxed(relaxed)
    );

    // chain ordering: cells beyond the active width are padded by shifting
    // every stored column position, so row r-1 column c sits MAX_COLS
    // shifts back. padding columns carry no valid distance and are skipped.
    logic [CW:0] pad_reg, pad_next;
    logic        padding;
    assign padding = (pad_reg != '0);

    always_comb
    begin
        fwd    = (state_reg == ST_FWD);
        e_side = !padding && (fwd ? (c_reg != '0) : (c_reg != col_last));
        e_up   = !padding && (fwd ? (r_reg != '0) : (r_reg != row_last));
        e_d1   = e_up && (fwd ? (c_reg != '0) : (c_reg != col_last));
        e_d2   = e_up && (fwd ? (c_reg != col_last) : (c_reg != '0));
    end

    logic [AW-1:0] cur_addr;
    assign cur_addr = {r_reg, c_reg};

    logic                  in_range;
    logic [DIST_WIDTH-1:0] rd_val;
    logic [DIST_WIDTH:0]   diff_a, diff_b;
    logic [OUT_W-1:0]      dist_sat;
    logic                  band_hit;

    always_comb
    begin
        in_range = ({1'b0, cmd_reg.col} < 7'(cols_n)) && ({1'b0, cmd_reg.row} < 7'(rows_n));
        rd_val   = any_reg ? dist_rd : DMAX;
        diff_a   = {1'b0, rd_val} - (DIST_WIDTH+1)'(band_reg);
        diff_b   = (DIST_WIDTH+1)'(band_reg) - {1'b0, rd_val};
        band_hit = any_reg && (rd_val != DMAX) &&
                   (diff_a[DIST_WIDTH] ? (diff_b < (DIST_WIDTH+1)'(BAND_TOL))
                                       : (diff_a < (DIST_WIDTH+1)'(BAND_TOL)));
        if ((DIST_WIDTH > OUT_W) && (rd_val > DIST_WIDTH'({OUT_W{1'b1}})))
            dist_sat = {OUT_W{1'b1}};
        else
            dist_sat = OUT_W'(rd_val);
    end

    // next state
    always_comb
    begin
        state_next   = state_reg;
        c_next       = c_reg;
        r_next       = r_reg;
        ph_next      = ph_reg;
        pad_next     = pad_reg;
        clr_next     = clr_reg;
        clr_cnt_next = clr_cnt_reg;
        cmd_next     = cmd_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (clr_reg)
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == (AW+1)'(CELLS-1))
                        clr_next = 1'b0;
                end
                else if (cmd.valid && !out_vld_reg)
                begin
                    cmd_next = cmd.data;
                    c_next = '0;
                    r_next = '0;
                    ph_next = '0;
                    case (cmd.data.action)
                        ACT_RUN:  state_next = ST_INIT;
                        ACT_READ: state_next = ST_RDWAIT;
                        default:  state_next = ST_RESP;
                    endcase
                end
            end
            ST_INIT:
            begin
                // ph 0 read occupancy, ph 1 write distance
                ph_next = ph_reg + 1'b1;
                if (ph_reg == 2'd1)
                begin
                    ph_next = '0;
                    if (c_reg == col_last)
                    begin
                        c_next = '0;
                        if (r_reg == row_last)
                        begin
                            r_next = '0;
                            pad_next = '0;
                            state_next = ST_FWD;
                        end
                        else
                            r_next = r_reg + 1'b1;
                    end
                    else
                        c_next = c_reg + 1'b1;
                end
            end
            ST_FWD, ST_BWD:
            begin
                if (padding)
                    pad_next = pad_reg - 1'b1;
                else
                begin
                    ph_next = ph_reg + 1'b1;
                    if (ph_reg == 2'd2)
                    begin
                        ph_next = '0;
                        if (fwd ? (c_reg == col_last) : (c_reg == '0))
                        begin
                            pad_next = (CW+1)'(MAX_COLS) - cols_n;
                            c_next = fwd ? '0 : col_last;
                            if (fwd ? (r_reg == row_last) : (r_reg == '0))
                            begin
                                pad_next = '0;
                                if (fwd)
                                begin
                                    state_next = ST_BWD;
                                    c_next = col_last;
                                    r_next = row_last;
                                end
                                else
                                    state_next = ST_RESP;
                            end
                            else
                                r_next = fwd ? r_reg + 1'b1 : r_reg - 1'b1;
                        end
                        else
                            c_next = fwd ? c_reg + 1'b1 : c_reg - 1'b1;
                    end
                end
            end
            ST_RDWAIT:
            begin
                ph_next = ph_reg + 1'b1;
                if (ph_reg == 2'd1)
                    state_next = ST_RESP;
            end
            ST_RESP:
            begin
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs and memory controls
    always_comb
    begin
        occ_we       = 1'b0;
        occ_addr     = cur_addr;
        occ_wd       = 1'b0;
        dist_we      = 1'b0;
        dist_addr    = cur_addr;
        dist_wd      = relaxed;
        chain_shift  = 1'b0;
        any_next     = any_reg;
        any_run_next = any_run_reg;
        out_next     = out_reg;
        out_vld_next = out_vld_reg && !rsp.ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (clr_reg)
                begin
                    occ_we   = 1'b1;
                    occ_addr = clr_cnt_reg[AW-1:0];
                end
                else
                    any_run_next = 1'b0;
            end
            ST_INIT:
            begin
                if (ph_reg == 2'd1)
                begin
                    dist_we = 1'b1;
                    dist_wd = occ_rd ? '0 : DMAX;
                    if (occ_rd)
                        any_run_next = 1'b1;
                end
            end
            ST_FWD, ST_BWD:
            begin
                if (padding)
                begin
                    chain_shift = 1'b1;
                end
                else if (ph_reg == 2'd2)
                begin
                    dist_we     = 1'b1;
                    chain_shift = 1'b1;
                end
            end
            ST_RDWAIT:
            begin
                dist_addr = {cmd_reg.row[RW-1:0], cmd_reg.col[CW-1:0]};
            end
            ST_RESP:
            begin
                dist_addr = {cmd_reg.row[RW-1:0], cmd_reg.col[CW-1:0]};
                out_vld_next = 1'b1;
                out_next.distance = '0;
                out_next.in_band  = 1'b0;
                if (cmd_reg.action == ACT_RUN)
                    any_next = any_run_reg;
                if (cmd_reg.action == ACT_WRITE)
                begin
                    occ_we   = 1'b1;
                    occ_addr = {cmd_reg.row[RW-1:0], cmd_reg.col[CW-1:0]};
                    occ_wd   = cmd_reg.occupied;
                end
                if (cmd_reg.action == ACT_READ)
                begin
                    out_next.distance = in_range ? dist_sat : {OUT_W{1'b1}};
                    out_next.in_band  = in_range && band_hit;
                end
                out_next.reachable = (cmd_reg.action == ACT_RUN) ? any_run_reg : any_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            c_reg       <= '0;
            r_reg       <= '0;
            ph_reg      <= '0;
            pad_reg     <= '0;
            any_reg     <= 1'b0;
            any_run_reg <= 1'b0;
            clr_reg     <= 1'b1;
            clr_cnt_reg <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            c_reg       <= c_next;
            r_reg       <= r_next;
            ph_reg      <= ph_next;
            pad_reg     <= pad_next;
            any_reg     <= any_next;
            any_run_reg <= any_run_next;
            clr_reg     <= clr_next;
            clr_cnt_reg <= clr_cnt_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        out_reg <= out_next;
    end

    assign cmd.ready = (state_reg == ST_IDLE) && !clr_reg && !out_vld_reg;
    assign rsp.valid = out_vld_reg;
    assign rsp.data  = out_reg;
endmodule

// ===== dv/grid_distance_transform_band_tb.sv =====
// testbench for the grid distance transform block: directed and random commands, scoreboarded
`timescale 1ns / 100ps

module grid_distance_transform_band_tb;
    import gdtb_pkg::*;

    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
    localparam int GRID_DIM    = 64;
    localparam int DIST_ALL1   = 65535;
    localparam int STALL_LIMIT = 200000;
    localparam int HOLD_CYCLES = 400;

    // distance predictor and store of expected response beats
    class dist_scoreboard;
        bit          occ_map[GRID_DIM*GRID_DIM];
        int          dist_map[GRID_DIM*GRID_DIM];
        bit          swept[GRID_DIM*GRID_DIM];
        bit          any_src;
        int          cols_reg = 64;
        int          rows_reg = 64;
        int          band_reg = 768;
        rsp_t        pending[$];
        int          errors;

        function int clamp_dim(int v);
            return (v < 1) ? 1 : ((v > GRID_DIM) ? GRID_DIM : v);
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, int val);
            case (idx)
                CFG_COLS: cols_reg = val & 'h7f;
                CFG_ROWS: rows_reg = val & 'h7f;
                CFG_BAND: band_reg = val & 'hffff;
                default: ;
            endcase
        endfunction

        function bit in_grid(int c, int r);
            return c < clamp_dim(cols_reg) && r < clamp_dim(rows_reg);
        endfunction

        // reads of a cell in the grid that no run ever wrote are not allowed
        function bit readable(int c, int r);
            return !in_grid(c, r) || swept[r*GRID_DIM+c];
        endfunction

        function void relax(ref int d, input int n, input int step);
            int cost;
            cost = dist_map[n] + step;
            if (cost > DIST_ALL1)
                cost = DIST_ALL1;
            if (cost < d)
                d = cost;
        endfunction

        // forward then backward chamfer sweep over the active grid
        function void run_sweep();
            int cols;
            int rows;
            int d;
            cols = clamp_dim(cols_reg);
            rows = clamp_dim(rows_reg);
            any_src = 0;
            for (int r = 0; r < rows; r++)
                for (int c = 0; c < cols; c++)
                begin
                    swept[r*GRID_DIM+c] = 1;
                    if (occ_map[r*GRID_DIM+c])
                    begin
                        dist_map[r*GRID_DIM+c] = 0;
                        any_src = 1;
                    end
                    else
                        dist_map[r*GRID_DIM+c] = DIST_ALL1;
                end
            for (int r = 0; r < rows; r++)
                for (int c = 0; c < cols; c++)
                begin
                    d = dist_map[r*GRID_DIM+c];
                    if (c > 0)
                        relax(d, r*GRID_DIM+c-1, STEP_STRAIGHT);
                    if (r > 0)
                    begin
                        relax(d, (r-1)*GRID_DIM+c, STEP_STRAIGHT);
                        if (c > 0)
                            relax(d, (r-1)*GRID_DIM+c-1, STEP_DIAG);
                        if (c + 1 < cols)
                            relax(d, (r-1)*GRID_DIM+c+1, STEP_DIAG);
                    end
                    dist_map[r*GRID_DIM+c] = d;
                end
            for (int r = rows - 1; r >= 0; r--)
                for (int c = cols - 1; c >= 0; c--)
                begin
                    d = dist_map[r*GRID_DIM+c];
                    if (c + 1 < cols)
                        relax(d, r*GRID_DIM+c+1, STEP_STRAIGHT);
                    if (r + 1 < rows)
                    begin
                        relax(d, (r+1)*GRID_DIM+c, STEP_STRAIGHT);
                        if (c + 1 < cols)
                            relax(d, (r+1)*GRID_DIM+c+1, STEP_DIAG);
                        if (c > 0)
                            relax(d, (r+1)*GRID_DIM+c-1, STEP_DIAG);
                    end
                    dist_map[r*GRID_DIM+c] = d;
                end
        endfunction

        function void note_command(cmd_t c);
            rsp_t exp_beat;
            int   d;
            int   diff;
            exp_beat = '0;
            case (c.action)
                ACT_WRITE: occ_map[c.row*GRID_DIM+c.col] = c.occupied;
                ACT_RUN: run_sweep();
                ACT_READ:
                begin
                    if (in_grid(c.col, c.row))
                    begin
                        d = dist_map[c.row*GRID_DIM+c.col];
                        diff = d - band_reg;
                        if (diff < 0)
                            diff = -diff;
                        exp_beat.in_band = any_src && d != DIST_ALL1 && diff < BAND_TOL;
                        exp_beat.distance = any_src ? d[15:0] : 16'hffff;
                    end
                    else
                        exp_beat.distance = 16'hffff;
                end
                default: ;
            endcase
            exp_beat.reachable = any_src;
            pending = {pending, exp_beat};
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_response(rsp_t got);
            rsp_t want;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected beat %h", got));
                return;
            end
            want = pending.pop_front();
            if (got.distance !== want.distance)
                report($sformatf("distance %h, want %h", got.distance, want.distance));
            if (got.in_band !== want.in_band)
                report($sformatf("in_band %b, want %b", got.in_band, want.in_band));
            if (got.reachable !== want.reachable)
                report($sformatf("reachable %b, want %b", got.reachable, want.reachable));
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    gdtb_if #(.payload_t(cmd_t)) cmd_ch ();
    gdtb_if #(.payload_t(rsp_t)) rsp_ch ();

    dist_scoreboard sb;
    int  tx_idle_pct;
    int  rx_idle_pct;
    bit  hold_pending;
    int  quiet_cycles;

    grid_distance_transform_band i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd_ch),
        .rsp      (rsp_ch),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // response side: random ready, plus one long hold-off on request
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_pending)
            begin
                hold_pending = 0;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // response monitor, values sampled are the ones from before the edge
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_response(rsp_ch.data);
    end

    // watchdog: cycles with no beat on either channel
    always @(posedge clk)
    begin
        if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // one command beat; valid stays high into the next call unless a gap is drawn
    task automatic send_cmd(cmd_t c);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= c;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        sb.note_command(c);
    endtask

    task automatic send_fields(logic [ACT_W-1:0] act, int c, int r, bit occ);
        cmd_t beat;
        beat.action   = act;
        beat.col      = c[COORD_W-1:0];
        beat.row      = r[COORD_W-1:0];
        beat.occupied = occ;
        send_cmd(beat);
    endtask

    // register write, only once the block has drained
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_we   <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    // random command, mostly inside the active grid; unsafe reads become writes
    task automatic send_random(int run_pct);
        int  pick;
        int  c;
        int  r;
        logic [ACT_W-1:0] act;
        pick = $urandom_range(99);
        if (pick < run_pct)
            act = ACT_RUN;
        else if (pick < run_pct + 4)
            act = ACT_UNUSED;
        else if (pick < 55)
            act = ACT_WRITE;
        else
            act = ACT_READ;
        if ($urandom_range(99) < 85)
        begin
            c = $urandom_range(sb.clamp_dim(sb.cols_reg) - 1);
            r = $urandom_range(sb.clamp_dim(sb.rows_reg) - 1);
        end
        else
        begin
            c = $urandom_range(63);
            r = $urandom_range(63);
        end
        if (act == ACT_READ && !sb.readable(c, r))
            act = ACT_WRITE;
        // sparse sources so that distances grow across the grid
        send_fields(act, c, r, $urandom_range(99) < 25);
    endtask

    initial
    begin
        sb = new();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_pending = 0;
        quiet_cycles = 0;
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_idx      <= CFG_COLS;
        cfg_data     <= '0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.data  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: small grid, diagonal band, source corner and stored-outside cell
        write_reg(CFG_COLS, 3);
        write_reg(CFG_ROWS, 2);
        write_reg(CFG_BAND, STEP_DIAG);
        send_fields(ACT_WRITE, 0, 0, 1);
        send_fields(ACT_WRITE, 63, 63, 1);
        send_fields(ACT_WRITE, 2, 1, 0);
        send_fields(ACT_RUN, 0, 0, 0);
        send_fields(ACT_READ, 0, 0, 0);
        send_fields(ACT_READ, 1, 1, 0);
        send_fields(ACT_READ, 2, 1, 0);
        send_fields(ACT_READ, 63, 63, 1);
        send_fields(ACT_UNUSED, 63, 63, 1);
        // clearing the only source leaves the grid unreachable
        send_fields(ACT_WRITE, 0, 0, 0);
        send_fields(ACT_RUN, 63, 63, 1);
        send_fields(ACT_READ, 1, 0, 0);
        // out-of-range sizes clamp to one column and the full height
        write_reg(CFG_COLS, 0);
        write_reg(CFG_ROWS, 127);
        write_reg(CFG_BAND, 0);
        send_fields(ACT_WRITE, 0, 40, 1);
        send_fields(ACT_RUN, 0, 0, 0);
        send_fields(ACT_READ, 0, 40, 0);
        send_fields(ACT_READ, 0, 63, 0);
        send_fields(ACT_READ, 1, 0, 0);
        write_reg(CFG_BAND, 65535);
        send_fields(ACT_READ, 0, 0, 0);

        // random phases: receiver idles more, then sender idles more, then neither
        for (int phase = 0; phase < 3; phase++)
        begin
            tx_idle_pct = (phase == 0) ? 36 : ((phase == 1) ? 55 : 0);
            rx_idle_pct = (phase == 0) ? 55 : ((phase == 1) ? 36 : 0);
            if (phase == 1)
            begin
                // full grid: runs are slow, so keep them few
                write_reg(CFG_COLS, 127);
                write_reg(CFG_ROWS, 64);
                write_reg(CFG_BAND, 256 * $urandom_range(1, 20) + $urandom_range(255));
            end
            else
            begin
                write_reg(CFG_COLS, $urandom_range(1, 14));
                write_reg(CFG_ROWS, $urandom_range(1, 14));
                write_reg(CFG_BAND, (phase == 0) ? 256 * $urandom_range(0, 4)
                                                 : $urandom_range(65535));
            end
            for (int n = 0; n < 34; n++)
            begin
                if (phase == 2 && n == 10)
                    hold_pending = 1;
                send_random((phase == 1) ? 6 : 12);
            end
        end

        cmd_ch.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
